>>> hw/rtl/bfaq_pkg.sv
`timescale 1ns / 1ps
package bfaq_pkg;
   localparam int DefMaxBits = 65536;
   localparam int DefMaxHashes = 30;
   localparam logic [31:0] FnvBasis = 32'h811c9dc5;
   localparam logic [31:0] FnvPrime = 32'h01000193;
   localparam logic [31:0] Golden = 32'h9e3779b9;
   localparam logic [31:0] MixMulA = 32'h85ebca6b;
   localparam logic [31:0] MixMulB = 32'hc2b2ae35;
   localparam logic [1:0] RegFilterBits = 2'd0;
   localparam logic [1:0] RegHashCount = 2'd1;

   typedef struct packed {
      logic start;
      logic query;
      logic [31:0] h1;
      logic [31:0] h2;
   } probe_cmd_type;
endpackage

>>> hw/rtl/bloom_filter_add_query.sv
`timescale 1ns / 1ps
// Bloom filter, add and query, over byte-streamed keys.
// req channel: one key byte per request; tlast ends the key, tuser is the request
// type (0 add, 1 query) taken from the last request. A non-last request with an
// invalid byte is ignored; a last one with an invalid byte closes the key.
// rsp channel: one response per key: was_query in tuser, maybe_present in tdata.
// Non-last requests are taken one per cycle once the store is cleared. A last request
// hashes through two finalizer multiply stages, then each probe costs one multiply,
// one start of the bit-serial modulo, the modulo itself and one store access; a
// query stops at its first clear bit. The bit store has one read and one write port.
// After reset the store is cleared one bit per cycle, during which no request is
// taken; csr writes are taken at any time.
// The response sits in an output register; while the receiver stalls, requests
// that are not last are still hashed, and a last request waits for the slot.
module bloom_filter_add_query import bfaq_pkg::*; #(
   parameter int MAX_BITS = DefMaxBits,
   parameter int MAX_HASHES = DefMaxHashes
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata, // [7:0] key_byte, [8] byte_valid
   input  logic req_tuser, // req_type
   input  logic req_tlast, // key_last
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata, // [0] maybe_present
   output logic rsp_tuser, // was_query
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int NW = $clog2(MAX_BITS + 1);

   logic [16:0] fbits_ff;
   logic [4:0] hcnt_ff;
   logic [31:0] ha_ff, hb_ff, ha_in, hb_in, ma, mb, mb_rot;
   logic [1:0] fin_ff;
   logic [31:0] fa_ff, fb_ff, fa_src, fb_src;
   logic fq_ff;
   logic rv_ff, rq_ff, rp_ff;
   logic clearing, pbusy, pres_valid, pres_present;
   logic [NW-1:0] bit_limit;
   logic [4:0] probe_limit;
   probe_cmd_type cmd;
   logic accept, wr;
   logic [31:0] xa, xb;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr[2:2])
         RegFilterBits[0]: csr_prdata = {15'd0, fbits_ff};
         default: csr_prdata = {27'd0, hcnt_ff};
      endcase
   end

   always_comb begin
      if (32'(fbits_ff) > 32'(MAX_BITS)) bit_limit = NW'(MAX_BITS & ~7);
      else bit_limit = NW'(fbits_ff & 17'h1fff8);
      probe_limit = (hcnt_ff > 5'(MAX_HASHES)) ? 5'(MAX_HASHES) : hcnt_ff;
   end

   // Non-last requests pass unless the store is clearing; a last one also needs the
   // finalizer, prober and response slot free.
   assign req_tready = !clearing && (!req_tlast ||
      (fin_ff == 2'd0 && !pbusy && !rv_ff));
   assign accept = req_tvalid && req_tready;

   assign xa = ha_ff ^ {24'd0, req_tdata[7:0]};
   assign xb = hb_ff ^ {24'd0, req_tdata[7:0]};
   assign ma = xa * FnvPrime;
   assign mb = xb * FnvPrime;
   assign mb_rot = {mb[26:0], mb[31:27]};
   always_comb begin
      ha_in = ha_ff;
      hb_in = hb_ff;
      if (accept && req_tdata[8]) begin
         ha_in = ma;
         hb_in = mb_rot;
      end
      if (accept && req_tlast) begin
         ha_in = FnvBasis;
         hb_in = FnvBasis ^ Golden;
      end
   end

   // Finalizer: the key's hashes are captured, then multiplied by A, then by B;
   // the last shift and xor feed the prober directly.
   assign fa_src = (accept && req_tdata[8]) ? ma : ha_ff;
   assign fb_src = (accept && req_tdata[8]) ? mb_rot : hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ha_ff <= FnvBasis;
         hb_ff <= FnvBasis ^ Golden;
         fin_ff <= 2'd0;
         rv_ff <= 1'b0;
         fbits_ff <= 17'(DefMaxBits);
         hcnt_ff <= 5'd7;
      end else begin
         ha_ff <= ha_in;
         hb_ff <= hb_in;
         if (wr && csr_paddr[2:2] == RegFilterBits[0]) fbits_ff <= csr_pwdata[16:0];
         if (wr && csr_paddr[2:2] == RegHashCount[0]) hcnt_ff <= csr_pwdata[4:0];
         case (fin_ff)
            2'd0: if (accept && req_tlast) fin_ff <= 2'd1;
            2'd1: fin_ff <= 2'd2;
            2'd2: fin_ff <= 2'd3;
            default: fin_ff <= 2'd0;
         endcase
         if (pres_valid) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
      case (fin_ff)
         2'd0: begin
            if (accept && req_tlast) begin
               fa_ff <= fa_src;
               fb_ff <= fb_src;
               fq_ff <= req_tuser;
            end
         end
         2'd1: begin
            fa_ff <= (fa_ff ^ (fa_ff >> 16)) * MixMulA;
            fb_ff <= (fb_ff ^ (fb_ff >> 16)) * MixMulA;
         end
         2'd2: begin
            fa_ff <= (fa_ff ^ (fa_ff >> 13)) * MixMulB;
            fb_ff <= (fb_ff ^ (fb_ff >> 13)) * MixMulB;
         end
         default: ;
      endcase
      if (pres_valid) begin
         rq_ff <= fq_ff;
         rp_ff <= pres_present;
      end
   end

   assign cmd.start = (fin_ff == 2'd3);
   assign cmd.query = fq_ff;
   assign cmd.h1 = fa_ff ^ (fa_ff >> 16);
   assign cmd.h2 = fb_ff ^ (fb_ff >> 16);

   bfaq_prober #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_prober (
      .clock(clock), .reset(reset), .cmd(cmd), .bit_limit(bit_limit),
      .probe_limit(probe_limit), .clearing(clearing), .busy(pbusy),
      .res_valid(pres_valid), .res_present(pres_present)
   );

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {7'd0, rp_ff};
   assign rsp_tuser = rq_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      pres_valid |-> !rv_ff) else $error("response overwritten");
   a_add_present: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rq_ff |-> rp_ff) else $error("add not acknowledged as present");
   a_fin_seq: assert property (@(posedge clock) disable iff (reset)
      fin_ff == 2'd1 |=> fin_ff == 2'd2) else $error("finalizer order");
endmodule

>>> hw/rtl/bfaq_mod_unit.sv
`timescale 1ns / 1ps
// Bit-serial 32-bit modulo: one quotient bit per cycle.
module bfaq_mod_unit import bfaq_pkg::*; #(
   parameter int NW = 17
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic done,
   output logic [NW-1:0] remainder
);
   logic [31:0] dvd_ff, dvd_in;
   logic [NW:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [NW:0] trial;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[NW-1:0], dvd_ff[31]};
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff[NW-1:0];
endmodule

>>> hw/rtl/bfaq_prober.sv
`timescale 1ns / 1ps
// Walks the probe positions of one key against the bit store.
module bfaq_prober import bfaq_pkg::*; #(
   parameter int MAX_BITS = DefMaxBits,
   parameter int MAX_HASHES = DefMaxHashes,
   localparam int NW = $clog2(MAX_BITS + 1),
   localparam int AW = $clog2(MAX_BITS),
   localparam int KW = 5
) (
   input  logic clock,
   input  logic reset,
   input  probe_cmd_type cmd,
   input  logic [NW-1:0] bit_limit,
   input  logic [KW-1:0] probe_limit,
   output logic clearing,
   output logic busy,
   output logic res_valid,
   output logic res_present
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMod = 3'd1;
   localparam logic [2:0] StRead = 3'd2;
   localparam logic [2:0] StCheck = 3'd3;
   localparam logic [2:0] StClear = 3'd4;
   localparam logic [2:0] StMul = 3'd5;

   logic mem [MAX_BITS];
   logic rd_ff;
   logic [2:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [KW-1:0] idx_ff, idx_in;
   logic [31:0] h1_ff, h2_ff, prod_ff, prod_in;
   logic query_ff, query_in, all_ff, all_in;
   logic valid_ff, valid_in;
   logic mod_start, mod_done;
   logic [NW-1:0] mod_rem;
   logic [AW-1:0] pos_ff, pos_in;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0] prod_full;

   bfaq_mod_unit #(.NW(NW)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start),
      .dividend(h1_ff + prod_ff), .divisor(bit_limit),
      .done(mod_done), .remainder(mod_rem)
   );

   assign prod_full = {{(32-KW){1'b0}}, idx_ff} * h2_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      idx_in = idx_ff;
      prod_in = prod_ff;
      query_in = query_ff;
      all_in = all_ff;
      pos_in = pos_ff;
      valid_in = 1'b0;
      mod_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = clr_ff;
      case (state_ff)
         StClear: begin
            wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_BITS - 1)) state_in = StIdle;
         end
         StIdle: begin
            if (cmd.start) begin
               query_in = cmd.query;
               all_in = 1'b1;
               idx_in = '0;
               if (bit_limit == '0 || probe_limit == '0) begin
                  valid_in = 1'b1;
               end else begin
                  state_in = StMul;
               end
            end
         end
         StMul: begin
            prod_in = prod_full;
            state_in = StRead;
            mod_start = 1'b0;
         end
         StRead: begin
            mod_start = 1'b1;
            state_in = StMod;
         end
         StMod: begin
            if (mod_done) begin
               pos_in = mod_rem[AW-1:0];
               state_in = StCheck;
            end
         end
         StCheck: begin
            // Read data for pos_ff is registered on entry to this state.
            if (query_ff) begin
               if (!rd_ff) all_in = 1'b0;
            end else begin
               wr_en = 1'b1;
               wr_addr = pos_ff;
            end
            if ((query_ff && !rd_ff) || idx_ff == probe_limit - 1'b1) begin
               valid_in = 1'b1;
               state_in = StIdle;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = StMul;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= (state_ff != StClear);
      rd_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         clr_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         valid_ff <= valid_in;
      end
      idx_ff <= idx_in;
      prod_ff <= prod_in;
      query_ff <= query_in;
      all_ff <= all_in;
      pos_ff <= pos_in;
      if (cmd.start && state_ff == StIdle) begin
         h1_ff <= cmd.h1;
         h2_ff <= cmd.h2;
      end
   end

   assign clearing = (state_ff == StClear);
   assign busy = (state_ff != StIdle) || valid_ff;
   assign res_valid = valid_ff;
   assign res_present = query_ff ? all_ff : 1'b1;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == StIdle) else $error("probe start while busy");
   a_check_after_mod: assert property (@(posedge clock) disable iff (reset)
      state_ff == StCheck |-> $past(state_ff) == StMod) else $error("bad check entry");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == StCheck |-> idx_ff < probe_limit) else $error("probe index range");
   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      probe_limit <= KW'(MAX_HASHES)) else $error("probe count above limit");
endmodule

>>> tb/bloom_filter_add_query_tb.sv
`timescale 1ns / 1ps
module bloom_filter_add_query_tb;
   import bfaq_pkg::*;

   localparam int StoreBits = DefMaxBits;
   localparam int ItemTarget = 1200;

   typedef struct {
      logic       query;
      logic [7:0] key_byte;
      logic       byte_valid;
      logic       key_last;
   } key_request_type;

   typedef struct {
      logic was_query;
      logic maybe_present;
   } membership_answer_type;

   typedef struct {
      key_request_type req;
      bit              known;
      logic            exp_maybe;
   } directed_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [15:0] req_tdata;  // [7:0] key_byte, [8] byte_valid
   logic req_tuser;         // req_type
   logic req_tlast;         // key_last
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;   // [0] maybe_present
   logic rsp_tuser;         // was_query
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bloom_filter_add_query i_dut (.*);

   // Shadow copy of the filter and its hash accumulators.
   logic [31:0] key_hash_a;
   logic [31:0] key_hash_b;
   bit shadow_store [StoreBits];
   logic [16:0] shadow_filter_bits;
   logic [4:0] shadow_hash_count;

   membership_answer_type pending_answers[$];
   int error_count;
   int items_sent;
   int answers_seen;
   logic [7:0] added_keys[$][$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] murmur_finalize(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * MixMulA;
      h = h ^ (h >> 13);
      h = h * MixMulB;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic void restart_hashes();
      key_hash_a = FnvBasis;
      key_hash_b = FnvBasis ^ Golden;
   endfunction

   // Applies one accepted request to the shadow filter; fired is set when it answers.
   function automatic void apply_key_request(input key_request_type r, output bit fired,
                                             output membership_answer_type ans);
      logic [31:0] h1, h2, tmp, nb, pos, step;
      int k;
      bit all_set;
      if (r.byte_valid) begin
         key_hash_a = (key_hash_a ^ {24'b0, r.key_byte}) * FnvPrime;
         tmp = (key_hash_b ^ {24'b0, r.key_byte}) * FnvPrime;
         key_hash_b = {tmp[26:0], tmp[31:27]};
      end
      fired = r.key_last;
      ans.was_query = r.query;
      ans.maybe_present = 1'b1;
      if (!r.key_last) return;
      h1 = murmur_finalize(key_hash_a);
      h2 = murmur_finalize(key_hash_b);
      restart_hashes();
      nb = (shadow_filter_bits > StoreBits) ? StoreBits : {15'b0, shadow_filter_bits};
      nb[2:0] = 3'b0;
      k = (shadow_hash_count > DefMaxHashes) ? DefMaxHashes : shadow_hash_count;
      all_set = 1'b1;
      if (nb != 0) begin
         for (int i = 0; i < k; i++) begin
            step = i;
            pos = (h1 + step * h2) % nb;
            if (r.query) begin
               if (!shadow_store[pos]) begin
                  all_set = 1'b0;
                  break;
               end
            end else begin
               shadow_store[pos] = 1'b1;
            end
         end
      end
      ans.maybe_present = r.query ? all_set : 1'b1;
   endfunction

   task automatic csr_write(input logic [1:0] reg_index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 1'b0} << 1;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_index == RegFilterBits) shadow_filter_bits = value[16:0];
      else shadow_hash_count = value[4:0];
   endtask

   // Sends one request; when exp_known is set the typed-in answer replaces the predicted one.
   task automatic send_request(input key_request_type r, input bit exp_known,
                               input logic exp_maybe);
      int gap;
      bit fired;
      membership_answer_type ans;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r.byte_valid, r.key_byte};
      req_tuser <= r.query;
      req_tlast <= r.key_last;
      do @(posedge clock); while (!req_tready);
      apply_key_request(r, fired, ans);
      if (r.byte_valid || r.key_last) items_sent++;
      if (fired) begin
         if (exp_known) ans.maybe_present = exp_maybe;
         pending_answers.push_back(ans);
      end
   endtask

   task automatic send_key(input logic [7:0] key_bytes[$], input logic query);
      key_request_type r;
      bit tail_invalid;
      tail_invalid = (key_bytes.size() == 0) || ($urandom_range(0, 4) == 0);
      foreach (key_bytes[i]) begin
         if ($urandom_range(0, 9) == 0) begin
            r = '{query: 1'($urandom_range(0, 1)), key_byte: 8'($urandom_range(0, 255)),
                  byte_valid: 1'b0, key_last: 1'b0};
            send_request(r, 1'b0, 1'b0);
         end
         r.query = (i == key_bytes.size() - 1 && !tail_invalid) ? query
                                                                : 1'($urandom_range(0, 1));
         r.key_byte = key_bytes[i];
         r.byte_valid = 1'b1;
         r.key_last = (i == key_bytes.size() - 1) && !tail_invalid;
         send_request(r, 1'b0, 1'b0);
      end
      if (tail_invalid) begin
         r = '{query: query, key_byte: 8'($urandom_range(0, 255)), byte_valid: 1'b0,
               key_last: 1'b1};
         send_request(r, 1'b0, 1'b0);
      end
   endtask

   // Let the block drain before touching its registers.
   task automatic wait_idle();
      wait (pending_answers.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off early on to back up the input.
   initial begin
      int stall;
      membership_answer_type exp;
      rsp_tready = 1'b0;
      answers_seen = 0;
      @(negedge reset);
      forever begin
         stall = (answers_seen == 40) ? 400 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("unexpected response: was_query=%0b maybe_present=%0b",
                   rsp_tuser, rsp_tdata[0]);
            error_count++;
         end else begin
            exp = pending_answers.pop_front();
            if (rsp_tuser !== exp.was_query) begin
               $error("was_query expected %0b actual %0b", exp.was_query, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[0] !== exp.maybe_present) begin
               $error("maybe_present expected %0b actual %0b", exp.maybe_present,
                      rsp_tdata[0]);
               error_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      logic [7:0] key[$];
      logic [16:0] phase_bits[];
      logic [4:0] phase_hashes[];
      int phase_len;
      logic query;

      phase_bits = '{17'd8, 17'd131071, 17'd0, 17'd1003, 17'd64, 17'd65536, 17'd200};
      phase_hashes = '{5'd1, 5'd31, 5'd5, 5'd30, 5'd0, 5'd7, 5'd3};
      error_count = 0;
      items_sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      restart_hashes();
      shadow_filter_bits = 17'd65536;
      shadow_hash_count = 5'd7;
      foreach (shadow_store[i]) shadow_store[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // {query, byte, valid, last}, typed-in answer where obvious.
      rows = '{
         '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b0},  // empty store: empty key absent
         '{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b1},  // add empty key
         '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0},
         '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h00, 1'b1, 1'b1}, 1'b1, 1'b1},
         '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0},
         '{'{1'b1, 8'hff, 1'b1, 1'b1}, 1'b0, 1'b0},
         '{'{1'b1, 8'hff, 1'b1, 1'b0}, 1'b0, 1'b0},  // type on a non-last byte is ignored
         '{'{1'b1, 8'h5a, 1'b0, 1'b0}, 1'b0, 1'b0},  // invalid byte, not last: dropped
         '{'{1'b0, 8'ha5, 1'b1, 1'b1}, 1'b1, 1'b1},
         '{'{1'b0, 8'hff, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b1, 8'ha5, 1'b1, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h12, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b1, 8'h99, 1'b0, 1'b1}, 1'b0, 1'b0},  // last with invalid byte closes key
         '{'{1'b0, 8'h12, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h33, 1'b0, 1'b1}, 1'b1, 1'b1},
         '{'{1'b0, 8'h12, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0}
      };
      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].exp_maybe);

      phase_len = ItemTarget / phase_bits.size();
      foreach (phase_bits[p]) begin
         req_tvalid <= 1'b0;
         wait_idle();
         if (p == 2) begin
            csr_write(RegHashCount, 32'hffff_ffe0 | phase_hashes[p]);
            csr_write(RegFilterBits, 32'hfffe_0000 | phase_bits[p]);
         end else begin
            csr_write(RegFilterBits, {15'b0, phase_bits[p]});
            csr_write(RegHashCount, {27'b0, phase_hashes[p]});
         end
         while (items_sent < 18 + phase_len * (p + 1)) begin
            query = 1'($urandom_range(0, 1));
            if (query && added_keys.size() > 0 && $urandom_range(0, 1)) begin
               key = added_keys[$urandom_range(0, added_keys.size() - 1)];
            end else begin
               key = {};
               if ($urandom_range(0, 19) != 0) begin
                  repeat ($urandom_range(1, 6)) key.push_back(8'($urandom_range(0, 255)));
               end
            end
            send_key(key, query);
            if (!query) begin
               added_keys.push_back(key);
               if (added_keys.size() > 40) void'(added_keys.pop_front());
            end
         end
      end
      req_tvalid <= 1'b0;

      wait (pending_answers.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
